@@ rtl/asb_pkg.sv @@
// affine sprite blitter: shared types, function codes and size constants
// used by asb_csr and affine_sprite_blitter_unit; depends on nothing
`timescale 1ns / 1ps

package asb_pkg;

   // largest sprite the texel store holds
   localparam int MAX_SPRITE_WIDTH  = 64;
   localparam int MAX_SPRITE_HEIGHT = 64;

   localparam int COL_BITS  = (MAX_SPRITE_WIDTH > 1) ? $clog2(MAX_SPRITE_WIDTH) : 1;
   localparam int ROW_BITS  = (MAX_SPRITE_HEIGHT > 1) ? $clog2(MAX_SPRITE_HEIGHT) : 1;
   localparam int ADDR_BITS = COL_BITS + ROW_BITS;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;

   // fixed field widths
   localparam int COORD_W = 32;
   localparam int COLOR_W = 16;
   localparam int SIZE_W  = 7;
   localparam int FRAC_W  = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      FUNC_LOAD     = 2'd0,
      FUNC_START    = 2'd1,
      FUNC_PIXEL    = 2'd2,
      FUNC_NEXT_ROW = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      REG_COL_STEP_X    = 3'd0,
      REG_COL_STEP_Y    = 3'd1,
      REG_ROW_STEP_X    = 3'd2,
      REG_ROW_STEP_Y    = 3'd3,
      REG_SPRITE_WIDTH  = 3'd4,
      REG_SPRITE_HEIGHT = 3'd5,
      REG_ALPHA_TEST_ON = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] col_step_x;
      logic signed [COORD_W-1:0] col_step_y;
      logic signed [COORD_W-1:0] row_step_x;
      logic signed [COORD_W-1:0] row_step_y;
      logic [SIZE_W-1:0]         sprite_width;
      logic [SIZE_W-1:0]         sprite_height;
      logic                      alpha_test_on;
   } cfg_type;

endpackage

@@ rtl/affine_sprite_blitter_unit.sv @@
// affine sprite blitter top level: coordinate registers, texel store, sample
// stage and result register; depends on asb_pkg and asb_csr
`timescale 1ns / 1ps

//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_stall     | func, texel fields, start_src_x/y
//  rsp     | out       | rsp_valid / rsp_stall     | write_enable, pixel_color
//  csr     | in/out    | psel, penable, pready     | paddr, pwdata, prdata
//
// one item per clock while the result is not stalled; a pixel result
// passes through the texel store read register, loaded when its item is accepted,
// then the result register. loads, starts and row steps finish at acceptance.
// synchronous reset clears control and coordinates; the texel store is not
// cleared. a stalled result holds the sample stage, which then stalls req.

module affine_sprite_blitter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_func,
   input  logic [5:0]                           req_texel_col,
   input  logic [5:0]                           req_texel_row,
   input  logic [15:0]                          req_texel_color,
   input  logic [7:0]                           req_texel_alpha,
   input  logic signed [31:0]                   req_start_src_x,
   input  logic signed [31:0]                   req_start_src_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_write_enable,
   output logic [15:0]                          rsp_pixel_color,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [asb_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [asb_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [asb_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   asb_pkg::cfg_type  cfg;
   asb_pkg::func_type func;

   logic accept;
   logic s1_advance;

   logic signed [asb_pkg::COORD_W-1:0] row_x_ff, row_y_ff, cur_x_ff, cur_y_ff;
   logic signed [asb_pkg::COORD_W-1:0] row_x_in, row_y_in, cur_x_in, cur_y_in;

   logic [asb_pkg::COLOR_W:0]   texel_mem_ff [asb_pkg::STORE_DEPTH];
   logic [asb_pkg::COLOR_W:0]   rd_data_ff;
   logic                        load_we;
   logic                        rd_en;
   logic [asb_pkg::ADDR_BITS-1:0] wr_addr;
   logic [asb_pkg::ADDR_BITS-1:0] rd_addr;

   logic [15:0] wlim;
   logic [15:0] hlim;
   logic        in_bounds;

   logic s1_valid_ff, s1_valid_in;
   logic s1_inside_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_we_ff;
   logic [asb_pkg::COLOR_W-1:0] rsp_color_ff;
   logic        s1_we;

   asb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign func       = asb_pkg::func_type'(req_func);
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;

   // coordinate registers
   always_comb begin
      row_x_in = row_x_ff;
      row_y_in = row_y_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (accept) begin
         case (func)
            asb_pkg::FUNC_START: begin
               row_x_in = req_start_src_x;
               row_y_in = req_start_src_y;
               cur_x_in = req_start_src_x;
               cur_y_in = req_start_src_y;
            end
            asb_pkg::FUNC_NEXT_ROW: begin
               row_x_in = row_x_ff + cfg.row_step_x;
               row_y_in = row_y_ff + cfg.row_step_y;
               cur_x_in = row_x_in;
               cur_y_in = row_y_in;
            end
            asb_pkg::FUNC_PIXEL: begin
               cur_x_in = cur_x_ff + cfg.col_step_x;
               cur_y_in = cur_y_ff + cfg.col_step_y;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff <= '0;
         row_y_ff <= '0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         row_x_ff <= row_x_in;
         row_y_ff <= row_y_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

   // sprite size clamped to the store
   assign wlim = (16'(cfg.sprite_width) > 16'(asb_pkg::MAX_SPRITE_WIDTH)) ?
                 16'(asb_pkg::MAX_SPRITE_WIDTH) : 16'(cfg.sprite_width);
   assign hlim = (16'(cfg.sprite_height) > 16'(asb_pkg::MAX_SPRITE_HEIGHT)) ?
                 16'(asb_pkg::MAX_SPRITE_HEIGHT) : 16'(cfg.sprite_height);

   // sign bit clear and integer part below the limit
   assign in_bounds = !cur_x_ff[31] && (cur_x_ff[31:16] < wlim) &&
                      !cur_y_ff[31] && (cur_y_ff[31:16] < hlim);

   assign rd_addr = {cur_y_ff[asb_pkg::FRAC_W +: asb_pkg::ROW_BITS],
                     cur_x_ff[asb_pkg::FRAC_W +: asb_pkg::COL_BITS]};
   assign wr_addr = {asb_pkg::ROW_BITS'(req_texel_row), asb_pkg::COL_BITS'(req_texel_col)};

   assign load_we = accept && (func == asb_pkg::FUNC_LOAD) &&
                    (32'(req_texel_col) < 32'(asb_pkg::MAX_SPRITE_WIDTH)) &&
                    (32'(req_texel_row) < 32'(asb_pkg::MAX_SPRITE_HEIGHT));
   assign rd_en   = accept && (func == asb_pkg::FUNC_PIXEL);

   // texel store: alpha flag on top of the color
   always_ff @(posedge clock) begin
      if (load_we) begin
         texel_mem_ff[wr_addr] <= {(req_texel_alpha != 8'd0), req_texel_color};
      end
      if (rd_en) begin
         rd_data_ff <= texel_mem_ff[rd_addr];
      end
   end

   // sample stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_inside_ff <= in_bounds;
      end
   end

   assign s1_we = s1_inside_ff && (!cfg.alpha_test_on || rd_data_ff[asb_pkg::COLOR_W]);

   // result register
   assign rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_we_ff    <= s1_we;
         rsp_color_ff <= s1_we ? rd_data_ff[asb_pkg::COLOR_W-1:0] : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_pixel_color  = rsp_color_ff;

endmodule

@@ rtl/asb_csr.sv @@
// affine sprite blitter: configuration registers behind an apb-style port
// depends on asb_pkg
`timescale 1ns / 1ps

module asb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [asb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [asb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [asb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output asb_pkg::cfg_type                 cfg
);

   asb_pkg::cfg_type      cfg_ff;
   asb_pkg::cfg_type      cfg_in;
   asb_pkg::reg_index_type reg_sel;
   logic                  wr_en;

   assign reg_sel = asb_pkg::reg_index_type'(paddr[asb_pkg::CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            asb_pkg::REG_COL_STEP_X:    cfg_in.col_step_x    = pwdata;
            asb_pkg::REG_COL_STEP_Y:    cfg_in.col_step_y    = pwdata;
            asb_pkg::REG_ROW_STEP_X:    cfg_in.row_step_x    = pwdata;
            asb_pkg::REG_ROW_STEP_Y:    cfg_in.row_step_y    = pwdata;
            asb_pkg::REG_SPRITE_WIDTH:  cfg_in.sprite_width  = pwdata[asb_pkg::SIZE_W-1:0];
            asb_pkg::REG_SPRITE_HEIGHT: cfg_in.sprite_height = pwdata[asb_pkg::SIZE_W-1:0];
            asb_pkg::REG_ALPHA_TEST_ON: cfg_in.alpha_test_on = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.col_step_x    <= 32'sd65536;
         cfg_ff.col_step_y    <= 32'sd0;
         cfg_ff.row_step_x    <= 32'sd0;
         cfg_ff.row_step_y    <= 32'sd65536;
         cfg_ff.sprite_width  <= asb_pkg::SIZE_W'(64);
         cfg_ff.sprite_height <= asb_pkg::SIZE_W'(64);
         cfg_ff.alpha_test_on <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         asb_pkg::REG_COL_STEP_X:    prdata = cfg_ff.col_step_x;
         asb_pkg::REG_COL_STEP_Y:    prdata = cfg_ff.col_step_y;
         asb_pkg::REG_ROW_STEP_X:    prdata = cfg_ff.row_step_x;
         asb_pkg::REG_ROW_STEP_Y:    prdata = cfg_ff.row_step_y;
         asb_pkg::REG_SPRITE_WIDTH:  prdata = asb_pkg::CSR_DATA_W'(cfg_ff.sprite_width);
         asb_pkg::REG_SPRITE_HEIGHT: prdata = asb_pkg::CSR_DATA_W'(cfg_ff.sprite_height);
         asb_pkg::REG_ALPHA_TEST_ON: prdata = asb_pkg::CSR_DATA_W'(cfg_ff.alpha_test_on);
         default:                    prdata = '0;
      endcase
   end

endmodule

@@ verif/testbench.sv @@
// testbench for affine_sprite_blitter_unit: directed and random items, random pixel
// results checked against an in-bench coordinate and texel store predictor, directed
// ones against their table entries; depends on asb_pkg and the blitter rtl
`timescale 1ns / 1ps

module testbench;
   import asb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_ITEMS    = 150;
   localparam int HOLD_CYCLES    = 120;
   localparam int DRAIN_CYCLES   = 4;
   localparam int ONE            = 65536;  // 1.0 in q16.16

   typedef struct packed {
      func_type    func;
      logic [5:0]  col;
      logic [5:0]  row;
      logic [15:0] color;
      logic [7:0]  alpha;
      logic [31:0] src_x;
      logic [31:0] src_y;
      logic        typed;
      logic        exp_we;
      logic [15:0] exp_color;
   } blit_item_t;

   typedef struct packed {
      logic        we;
      logic [15:0] color;
   } pixel_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_func;
   logic [5:0]            req_texel_col;
   logic [5:0]            req_texel_row;
   logic [15:0]           req_texel_color;
   logic [7:0]            req_texel_alpha;
   logic signed [31:0]    req_start_src_x;
   logic signed [31:0]    req_start_src_y;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_write_enable;
   logic [15:0]           rsp_pixel_color;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   affine_sprite_blitter_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_texel_col    (req_texel_col),
      .req_texel_row    (req_texel_row),
      .req_texel_color  (req_texel_color),
      .req_texel_alpha  (req_texel_alpha),
      .req_start_src_x  (req_start_src_x),
      .req_start_src_y  (req_start_src_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_enable (rsp_write_enable),
      .rsp_pixel_color  (rsp_pixel_color),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // predictor state
   logic [15:0] texel_mem [STORE_DEPTH];
   logic        alpha_mem [STORE_DEPTH];
   bit          texel_loaded [STORE_DEPTH];
   logic [31:0] row_x, row_y, cur_x, cur_y;
   cfg_type     cfg_shadow;
   pixel_t      pending_pixels [$];

   int error_count = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   bit sender_gaps = 1'b1;
   bit hold_request = 1'b0;

   // corner texels, zero alpha, bounds, negative and wrapping coordinates
   blit_item_t directed_tab [26] = '{
      '{FUNC_LOAD, 6'd0, 6'd0, 16'hFFFF, 8'hFF, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_LOAD, 6'd63, 6'd63, 16'h0000, 8'h01, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_LOAD, 6'd1, 6'd0, 16'h1234, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_LOAD, 6'd63, 6'd0, 16'hA5A5, 8'h80, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_LOAD, 6'd0, 6'd63, 16'h5A5A, 8'h7F, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_START, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'hFFFF},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'h0000},
      '{FUNC_START, 6'd0, 6'd0, 16'h0, 8'h0, 32'h003F_0000, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'hA5A5},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'h0000},
      '{FUNC_START, 6'd0, 6'd0, 16'h0, 8'h0, 32'h003F_FFFF, 32'h003F_FFFF, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'h0000},
      '{FUNC_NEXT_ROW, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'h0000},
      '{FUNC_START, 6'd0, 6'd0, 16'h0, 8'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'h0000},
      '{FUNC_START, 6'd0, 6'd0, 16'h0, 8'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'h0000},
      '{FUNC_START, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h003F_0000, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'h5A5A},
      '{FUNC_NEXT_ROW, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'h0000},
      '{FUNC_START, 6'd0, 6'd0, 16'h0, 8'h0, 32'h7FFF_0000, 32'h0, 1'b0, 1'b0, 16'h0},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'h0000},
      '{FUNC_PIXEL, 6'd0, 6'd0, 16'h0, 8'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'h0000}
   };

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // sample lies inside the clamped sprite, addr is its store entry
   function automatic logic sample_inside(input logic [31:0] x, input logic [31:0] y,
                                          output logic [ADDR_BITS-1:0] addr);
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      w = (cfg_shadow.sprite_width > MAX_SPRITE_WIDTH) ?
          SIZE_W'(MAX_SPRITE_WIDTH) : cfg_shadow.sprite_width;
      h = (cfg_shadow.sprite_height > MAX_SPRITE_HEIGHT) ?
          SIZE_W'(MAX_SPRITE_HEIGHT) : cfg_shadow.sprite_height;
      addr = {y[FRAC_W +: ROW_BITS], x[FRAC_W +: COL_BITS]};
      return !x[31] && !y[31] && (x[30:FRAC_W] < w) && (y[30:FRAC_W] < h);
   endfunction

   // updates the predictor for one accepted item, queues the pixel it causes
   task automatic advance_blitter(input blit_item_t it);
      logic [ADDR_BITS-1:0] addr;
      pixel_t px;
      case (it.func)
         FUNC_LOAD: begin
            addr = {it.row, it.col};
            texel_mem[addr] = it.color;
            alpha_mem[addr] = |it.alpha;
            texel_loaded[addr] = 1'b1;
         end
         FUNC_START: begin
            row_x = it.src_x;
            row_y = it.src_y;
            cur_x = row_x;
            cur_y = row_y;
         end
         FUNC_NEXT_ROW: begin
            row_x = row_x + cfg_shadow.row_step_x;
            row_y = row_y + cfg_shadow.row_step_y;
            cur_x = row_x;
            cur_y = row_y;
         end
         default: begin
            px = '0;
            if (sample_inside(cur_x, cur_y, addr) &&
                (!cfg_shadow.alpha_test_on || alpha_mem[addr])) begin
               px.we = 1'b1;
               px.color = texel_mem[addr];
            end
            if (it.typed) px = {it.exp_we, it.exp_color};
            pending_pixels.push_back(px);
            cur_x = cur_x + cfg_shadow.col_step_x;
            cur_y = cur_y + cfg_shadow.col_step_y;
         end
      endcase
   endtask

   function automatic blit_item_t random_item();
      blit_item_t it;
      it.func = func_type'($urandom_range(0, 3));
      it.col = 6'($urandom);
      it.row = 6'($urandom);
      it.color = 16'($urandom);
      it.alpha = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      it.src_x = $urandom;
      it.src_y = $urandom;
      it.typed = 1'b0;
      it.exp_we = 1'b0;
      it.exp_color = '0;
      return it;
   endfunction

   task automatic drive_item(input blit_item_t it);
      int gap;
      req_valid <= 1'b1;
      req_func <= it.func;
      req_texel_col <= it.col;
      req_texel_row <= it.row;
      req_texel_color <= it.color;
      req_texel_alpha <= it.alpha;
      req_start_src_x <= it.src_x;
      req_start_src_y <= it.src_y;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      advance_blitter(it);
      items_sent++;
      if (sender_gaps) begin
         gap = gap_len();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // a pixel about to land on a never loaded texel gets that texel loaded first
   task automatic issue(input blit_item_t it);
      logic [ADDR_BITS-1:0] addr;
      blit_item_t fill;
      if (it.func == FUNC_PIXEL && sample_inside(cur_x, cur_y, addr) && !texel_loaded[addr])
      begin
         fill = random_item();
         fill.func = FUNC_LOAD;
         fill.col = addr[COL_BITS-1:0];
         fill.row = addr[ADDR_BITS-1:COL_BITS];
         drive_item(fill);
      end
      drive_item(it);
   endtask

   task automatic csr_access(input logic wr, input reg_index_type idx,
                             input logic [31:0] data, output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] reg_value(input reg_index_type idx);
      case (idx)
         REG_COL_STEP_X:    return cfg_shadow.col_step_x;
         REG_COL_STEP_Y:    return cfg_shadow.col_step_y;
         REG_ROW_STEP_X:    return cfg_shadow.row_step_x;
         REG_ROW_STEP_Y:    return cfg_shadow.row_step_y;
         REG_SPRITE_WIDTH:  return 32'(cfg_shadow.sprite_width);
         REG_SPRITE_HEIGHT: return 32'(cfg_shadow.sprite_height);
         default:           return 32'(cfg_shadow.alpha_test_on);
      endcase
   endfunction

   // write, then read back
   task automatic write_reg(input reg_index_type idx, input logic [31:0] data);
      logic [31:0] rdata;
      csr_access(1'b1, idx, data, rdata);
      case (idx)
         REG_COL_STEP_X:    cfg_shadow.col_step_x = data;
         REG_COL_STEP_Y:    cfg_shadow.col_step_y = data;
         REG_ROW_STEP_X:    cfg_shadow.row_step_x = data;
         REG_ROW_STEP_Y:    cfg_shadow.row_step_y = data;
         REG_SPRITE_WIDTH:  cfg_shadow.sprite_width = data[SIZE_W-1:0];
         REG_SPRITE_HEIGHT: cfg_shadow.sprite_height = data[SIZE_W-1:0];
         default:           cfg_shadow.alpha_test_on = data[0];
      endcase
      csr_access(1'b0, idx, '0, rdata);
      if (rdata !== reg_value(idx)) begin
         $error("register %s expected %h actual %h", idx.name(), reg_value(idx), rdata);
         error_count++;
      end
   endtask

   task automatic set_config(input logic [31:0] cdx, input logic [31:0] cdy,
                             input logic [31:0] rdx, input logic [31:0] rdy,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] alpha_on);
      write_reg(REG_COL_STEP_X, cdx);
      write_reg(REG_COL_STEP_Y, cdy);
      write_reg(REG_ROW_STEP_X, rdx);
      write_reg(REG_ROW_STEP_Y, rdy);
      write_reg(REG_SPRITE_WIDTH, w);
      write_reg(REG_SPRITE_HEIGHT, h);
      write_reg(REG_ALPHA_TEST_ON, alpha_on);
   endtask

   function automatic logic [31:0] rand_step();
      return 32'(int'($urandom_range(0, 6 * ONE)) - 3 * ONE);
   endfunction

   // stop offering items until every pixel result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one sprite: start point near the sprite, a few rows of pixels
   task automatic run_blit();
      int span_w, span_h, rows, cols, xi, yi;
      blit_item_t it;
      span_w = (cfg_shadow.sprite_width == 0) ? 8 :
               (cfg_shadow.sprite_width > MAX_SPRITE_WIDTH) ? MAX_SPRITE_WIDTH :
               int'(cfg_shadow.sprite_width);
      span_h = (cfg_shadow.sprite_height == 0) ? 8 :
               (cfg_shadow.sprite_height > MAX_SPRITE_HEIGHT) ? MAX_SPRITE_HEIGHT :
               int'(cfg_shadow.sprite_height);
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 16);
      xi = int'($urandom_range(0, span_w + 3)) - 2;
      yi = int'($urandom_range(0, span_h + 3)) - 2;
      it = random_item();
      it.func = FUNC_START;
      it.src_x = {xi[15:0], 16'($urandom)};
      it.src_y = {yi[15:0], 16'($urandom)};
      issue(it);
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            it = random_item();
            it.func = FUNC_PIXEL;
            issue(it);
         end
         if (r < rows - 1) begin
            it = random_item();
            it.func = FUNC_NEXT_ROW;
            issue(it);
         end
      end
   endtask

   // pixel results: check against the oldest expectation, stall at random or when a hold is requested
   initial begin
      int stall_left;
      bit stall_on;
      stall_left = 0;
      stall_on = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel result with none expected: write_enable %0b pixel_color %h",
                      rsp_write_enable, rsp_pixel_color);
               error_count++;
            end else begin
               pixel_t want;
               want = pending_pixels.pop_front();
               if (rsp_write_enable !== want.we) begin
                  $error("write_enable expected %0b actual %0b", want.we, rsp_write_enable);
                  error_count++;
               end
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color expected %h actual %h", want.color, rsp_pixel_color);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_on = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left > 0) begin
            stall_left--;
         end else begin
            stall_on = ($urandom_range(0, 99) < 40);
            stall_left = stall_on ? gap_len() : $urandom_range(1, 40);
         end
         rsp_stall <= stall_on;
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      blit_item_t it;
      int first, pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_LOAD;
      req_texel_col = '0;
      req_texel_row = '0;
      req_texel_color = '0;
      req_texel_alpha = '0;
      req_start_src_x = '0;
      req_start_src_y = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_shadow = '{col_step_x: ONE, col_step_y: 0, row_step_x: 0, row_step_y: ONE,
                     sprite_width: SIZE_W'(64), sprite_height: SIZE_W'(64),
                     alpha_test_on: 1'b1};
      row_x = '0;
      row_y = '0;
      cur_x = '0;
      cur_y = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_tab[i]) issue(directed_tab[i]);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         case (p)
            0: set_config(ONE, 0, 0, ONE, 64, 64, 1);
            1: set_config(ONE, 0, 0, ONE, 16, 8, 0);
            2: set_config(ONE, 0, 0, ONE, 0, 64, 1);
            3: set_config(ONE / 2, ONE / 4, -ONE / 4, ONE / 2, 127, 65, 1);
            4: set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          64, 64, 0);
            5: set_config(0, 0, 0, 0, 1, 1, 1);
            6: set_config(-ONE, 0, 0, -ONE, 64, 1, 0);
            default: set_config(rand_step(), rand_step(), rand_step(), rand_step(),
                                {25'($urandom), 7'($urandom_range(1, 64))},
                                {25'($urandom), 7'($urandom_range(1, 64))},
                                32'($urandom));
         endcase
         sender_gaps = (p % 3) != 2;
         if (p == 1) begin
            // receiver holds off while a gapless pixel run backs up the block
            sender_gaps = 1'b0;
            hold_request = 1'b1;
            it = random_item();
            it.func = FUNC_START;
            it.src_x = '0;
            it.src_y = '0;
            issue(it);
            repeat (40) begin
               it = random_item();
               it.func = FUNC_PIXEL;
               issue(it);
            end
            sender_gaps = 1'b1;
         end
         first = items_sent;
         while (items_sent - first < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               run_blit();
            end else if (pick < 85) begin
               it = random_item();
               it.func = FUNC_LOAD;
               issue(it);
            end else begin
               issue(random_item());
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
